FILE: design/apq_pkg.sv
package apq_pkg;

  localparam int DATA_W        = 16;
  localparam int STATUS_W      = 2;
  localparam int WORD_W        = 2 * DATA_W;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Qualifies one word of read data handed to the comparator.
  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

FILE: design/array_priority_queue_top.sv
// Priority queue of DEPTH priority/payload entries held unsorted in a RAM.
// Input channel (s_axis_*): tuser carries the opcode, 0 to insert and 1 to
// remove the entry of highest priority; tdata carries the entry to insert.
// Output channel (m_axis_*): exactly one item per input item, holding the
// removed entry (zero on insert) and a status of ok, overflow or empty.
// An insert, an overflowing insert or a remove from an empty queue goes
// straight to the finishing state, which moves its result into the output
// register, and the next item can be accepted once the sequencer is back in
// idle. A remove scans the slots below the fill count before it finishes,
// and the next item waits for it: one comparator is shared across the scan,
// reading one RAM word a cycle through the registered read port, and the
// last entry is written into the vacated slot when it arrives.
// The input side is ready only while no item is in progress; it may accept
// the next item while a result still waits in the output register. A stall
// on the output holds the finished result in the sequencer until the output
// register is free. Reset empties the queue at once; the RAM is not cleared,
// since only slots below the fill count are ever read.
module array_priority_queue_top #(
  parameter int DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // priority_req [15:0], payload [31:16]
  input  logic [0:0]  s_axis_tuser,   // opcode [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // out_priority [15:0], out_payload [31:16],
                                      // status [33:32], zero [39:34]
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = apq_pkg::DATA_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] fill_count;

  // Scan bookkeeping: address being issued, and the word now on the read port.
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] last_addr;
  logic          issue;
  logic          rd_pend;
  logic          rd_first;
  logic          rd_last;
  logic [AW-1:0] rd_idx;

  // Finished result, waiting for the output register.
  logic [DW-1:0]               res_pri;
  logic [DW-1:0]               res_pay;
  logic [apq_pkg::STATUS_W-1:0] res_status;

  logic [DW-1:0]               out_pri;
  logic [DW-1:0]               out_pay;
  logic [apq_pkg::STATUS_W-1:0] out_status;

  logic                        in_accept;
  logic                        in_op;
  logic                        full;
  logic                        empty;
  logic                        scan_done;
  logic                        out_free;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [apq_pkg::WORD_W-1:0]  mem_wdata;
  logic [apq_pkg::WORD_W-1:0]  mem_rdata;

  apq_pkg::scan_ctl_t          scan_ctl;
  logic [DW-1:0]               sel_pri;
  logic [DW-1:0]               sel_pay;
  logic [AW-1:0]               sel_idx;

  assign s_axis_tready = (state == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_op         = s_axis_tuser[0];
  assign full          = (fill_count == CW'(DEPTH));
  assign empty         = (fill_count == '0);
  assign scan_done     = rd_pend && rd_last;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign scan_ctl.valid = rd_pend;
  assign scan_ctl.first = rd_first;

  // Insert writes the tail slot; the end of a scan moves the last entry,
  // which is the word then on the read port, into the winner's slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_count[AW-1:0];
    mem_wdata = s_axis_tdata;
    if (in_accept && (in_op == apq_pkg::OP_INSERT) && !full) begin
      mem_we = 1'b1;
    end else if (scan_done) begin
      mem_we    = 1'b1;
      mem_waddr = sel_idx;
      mem_wdata = mem_rdata;
    end
  end

  apq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_addr),
    .rdata (mem_rdata)
  );

  apq_scan #(
    .AW (AW)
  ) u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .idx     (rd_idx),
    .rd_pri  (mem_rdata[DW-1:0]),
    .rd_pay  (mem_rdata[2*DW-1:DW]),
    .sel_pri (sel_pri),
    .sel_pay (sel_pay),
    .sel_idx (sel_idx)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      issue      <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      rd_pend <= issue;
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_FIN;
            if (in_op == apq_pkg::OP_INSERT) begin
              if (!full) begin
                fill_count <= fill_count + CW'(1);
              end
            end else if (!empty) begin
              state <= S_SCAN;
              issue <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (issue && (scan_addr == last_addr)) begin
            issue <= 1'b0;
          end
          if (scan_done) begin
            fill_count <= fill_count - CW'(1);
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan addressing and the finished result; no reset needed.
  always_ff @(posedge clk) begin
    rd_idx   <= scan_addr;
    rd_first <= (scan_addr == '0);
    rd_last  <= (scan_addr == last_addr);
    if (issue && (scan_addr != last_addr)) begin
      scan_addr <= scan_addr + AW'(1);
    end
    if (in_accept) begin
      scan_addr  <= '0;
      last_addr  <= AW'(fill_count - CW'(1));
      res_pri    <= '0;
      res_pay    <= '0;
      res_status <= apq_pkg::ST_OK;
      if (in_op == apq_pkg::OP_INSERT) begin
        if (full) begin
          res_status <= apq_pkg::ST_OVERFLOW;
        end
      end else if (empty) begin
        res_status <= apq_pkg::ST_EMPTY;
      end
    end
    if (scan_done) begin
      res_pri <= sel_pri;
      res_pay <= sel_pay;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      out_pri    <= res_pri;
      out_pay    <= res_pay;
      out_status <= res_status;
    end
  end

  assign m_axis_tdata = {6'd0, out_status, out_pay, out_pri};

endmodule

FILE: design/apq_mem.sv
module apq_mem #(
  parameter int DEPTH = apq_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [apq_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [apq_pkg::WORD_W-1:0] rdata
);

  logic [apq_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/apq_scan.sv
module apq_scan #(
  parameter int AW = 4
) (
  input  logic                       clk,
  input  apq_pkg::scan_ctl_t         ctl,
  input  logic [AW-1:0]              idx,
  input  logic [apq_pkg::DATA_W-1:0] rd_pri,
  input  logic [apq_pkg::DATA_W-1:0] rd_pay,
  output logic [apq_pkg::DATA_W-1:0] sel_pri,
  output logic [apq_pkg::DATA_W-1:0] sel_pay,
  output logic [AW-1:0]              sel_idx
);

  logic [apq_pkg::DATA_W-1:0] best_pri;
  logic [apq_pkg::DATA_W-1:0] best_pay;
  logic [AW-1:0]              best_idx;
  logic                       take;

  // A strict compare keeps the lower slot when priorities are equal.
  assign take    = ctl.first || (rd_pri > best_pri);
  assign sel_pri = take ? rd_pri : best_pri;
  assign sel_pay = take ? rd_pay : best_pay;
  assign sel_idx = take ? idx : best_idx;

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      best_pri <= sel_pri;
      best_pay <= sel_pay;
      best_idx <= sel_idx;
    end
  end

endmodule

FILE: test/apq_checker.sv
module apq_checker #(
  parameter int DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // priority_req [15:0], payload [31:16]
  input  logic [0:0]  s_axis_tuser,   // opcode [0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // out_priority [15:0], out_payload [31:16],
                                      // status [33:32], zero [39:34]
  output int          errors,
  output int          pending,
  output int          removes_ok,
  output int          overflows,
  output int          empties,
  output int          peak_fill
);
  timeunit 1ns;
  timeprecision 1ps;

  import apq_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]   pri;
    logic [DATA_W-1:0]   pay;
    logic [STATUS_W-1:0] status;
  } pq_result_t;

  logic [DATA_W-1:0] slot_pri [DEPTH];
  logic [DATA_W-1:0] slot_pay [DEPTH];
  int                fill;
  pq_result_t        expected_q [$];

  int mismatch_count = 0;
  int outstanding    = 0;
  int result_count   = 0;
  int remove_count   = 0;
  int overflow_count = 0;
  int empty_count    = 0;
  int fill_peak      = 0;

  assign errors     = mismatch_count;
  assign pending    = outstanding;
  assign removes_ok = remove_count;
  assign overflows  = overflow_count;
  assign empties    = empty_count;
  assign peak_fill  = fill_peak;

  // Applies one operation to the shadow queue and gives the result it must produce.
  function automatic pq_result_t apply_op(logic op, logic [DATA_W-1:0] pri,
                                          logic [DATA_W-1:0] pay);
    pq_result_t r;
    int         best;
    int         i;
    r = '0;
    if (op == OP_INSERT) begin
      if (fill >= DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        slot_pri[fill] = pri;
        slot_pay[fill] = pay;
        fill++;
        if (fill > fill_peak) fill_peak = fill;
        r.status = ST_OK;
      end
    end else if (fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // A strict compare keeps the lowest slot when priorities are equal.
      best = 0;
      for (i = 1; i < fill; i++) begin
        if (slot_pri[i] > slot_pri[best]) best = i;
      end
      r.pri = slot_pri[best];
      r.pay = slot_pay[best];
      r.status = ST_OK;
      slot_pri[best] = slot_pri[fill-1];
      slot_pay[best] = slot_pay[fill-1];
      fill--;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t: result %0d, %s: got %h, expected %h",
               $time, result_count, what, got, want);
  endtask

  task automatic check_result(logic [39:0] word);
    pq_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with nothing outstanding", word, '0);
      return;
    end
    want = expected_q.pop_front();
    if (word[15:0] !== want.pri)
      report_mismatch("priority", word[15:0], want.pri);
    if (word[31:16] !== want.pay)
      report_mismatch("payload", word[31:16], want.pay);
    if (word[33:32] !== want.status)
      report_mismatch("status", word[33:32], want.status);
    if (word[39:34] !== '0)
      report_mismatch("padding bits", word[39:34], '0);
    case (want.status)
      ST_OVERFLOW: overflow_count++;
      ST_EMPTY:    empty_count++;
      default: begin
        if (want.pri != '0 || want.pay != '0) remove_count++;
      end
    endcase
    result_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(apply_op(s_axis_tuser[0], s_axis_tdata[15:0],
                                      s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready)
        check_result(m_axis_tdata);
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: test/tb_array_priority_queue_top.sv
module tb_array_priority_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  import apq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 485;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // priority_req [15:0], payload [31:16]
  logic [0:0]  s_axis_tuser;   // opcode [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_priority [15:0], out_payload [31:16],
                               // status [33:32], zero [39:34]

  int errors;
  int pending;
  int removes_ok;
  int overflows;
  int empties;
  int peak_fill;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int sender_pct = 0;
  int stall_pct  = 0;

  // Long receiver hold-offs are asked for by the stimulus and carried out by
  // the receiver, each side writing only its own counter.
  int hold_asked = 0;
  int hold_taken = 0;

  int items_sent  = 0;
  int cycle_count = 0;

  array_priority_queue_top #(.DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  apq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending),
    .removes_ok    (removes_ok),
    .overflows     (overflows),
    .empties       (empties),
    .peak_fill     (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The run is abandoned if it goes on far longer than the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver changes tready at the falling edge. A pending hold-off keeps
  // it low for a long stretch, counted here, so that the queue backs up into
  // the input side while the sender keeps offering items.
  initial begin : receiver
    int k;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_taken != hold_asked) begin
        hold_taken++;
        m_axis_tready <= 1'b0;
        for (k = 1; k < HOLD_CYCLES; k++) @(negedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offers one item, after a random run of idle cycles, and returns at the
  // falling edge that follows its acceptance. Every call drives tvalid once
  // per falling edge, so it is never lowered and raised in the same step.
  task automatic send_item(logic op, logic [15:0] pri, logic [15:0] pay);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < sender_pct) gap++;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pay, pri};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
  endtask

  // Holds the input idle until every expected result has come back.
  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Priorities lean towards a tiny range, so that ties are common, and towards
  // both extremes; the rest are spread over the whole field.
  function automatic logic [15:0] pick_priority();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return 16'($urandom_range(3));
    if (roll < 35) return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  // Random traffic in bursts. A burst leans towards filling the queue, towards
  // draining it, or towards neither, so that the run keeps passing through the
  // full and empty states with ties and extremes stored in between. Removes
  // carry random fields as well, which the block must ignore.
  task automatic run_random(int count);
    int   sent;
    int   burst;
    int   insert_pct;
    logic op;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(2))
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        if (sent < count) begin
          op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
          send_item(op, pick_priority(), 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    int i;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = OP_INSERT;
    s_axis_tdata  = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. A remove from the empty queue comes first, with every
    // field bit set so that the ignored fields are shown to be ignored.
    send_item(OP_REMOVE, 16'hFFFF, 16'hFFFF);
    // Fill to the brim: both extremes of each field, two equal priorities in
    // a row and a second copy of the top priority further along.
    send_item(OP_INSERT, 16'h0000, 16'hFFFF);
    send_item(OP_INSERT, 16'hFFFF, 16'h0000);
    send_item(OP_INSERT, 16'h0007, 16'h1111);
    send_item(OP_INSERT, 16'h0007, 16'h2222);
    send_item(OP_INSERT, 16'h8000, 16'h5555);
    send_item(OP_INSERT, 16'h0001, 16'hAAAA);
    send_item(OP_INSERT, 16'hFFFF, 16'h3333);
    for (i = 0; i < DEPTH - 7; i++) send_item(OP_INSERT, pick_priority(), 16'($urandom));
    // The queue is full now, so this insert must overflow and be dropped.
    send_item(OP_INSERT, 16'hFFFF, 16'h7777);
    // The first two removes must return the two top-priority entries in
    // order of their slots, then the scan carries on over moved entries.
    repeat (6) send_item(OP_REMOVE, 16'($urandom), 16'($urandom));
    drain_all();

    // Phase one: no idling on either side, with one long hold-off on the
    // output while the sender keeps pushing.
    sender_pct = 0;
    stall_pct  = 0;
    hold_asked++;
    run_random(PHASE_ITEMS);
    drain_all();

    // Phase two: the sender is idle in most cycles.
    sender_pct = 75;
    stall_pct  = 0;
    run_random(PHASE_ITEMS);
    drain_all();

    // Phase three: the receiver stalls in most cycles.
    sender_pct = 0;
    stall_pct  = 75;
    run_random(PHASE_ITEMS);
    drain_all();

    // Phase four: light idling on both sides, and a second hold-off.
    sender_pct = 18;
    stall_pct  = 18;
    hold_asked++;
    run_random(PHASE_ITEMS);
    drain_all();

    // Allow longer than the slowest remove, so that a stray
    // result would still be caught.
    repeat (2 * (DEPTH + 3)) @(negedge clk);

    $display("Sent %0d items in four idling phases: %0d removes returned an entry,",
             items_sent, removes_ok);
    $display("%0d inserts overflowed, %0d removes found the queue empty, peak fill %0d of %0d.",
             overflows, empties, peak_fill, DEPTH);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/apq_pkg.sv
design/apq_mem.sv
design/apq_scan.sv
design/array_priority_queue_top.sv
test/apq_checker.sv
test/tb_array_priority_queue_top.sv
